@@ rtl/core/tlcd_pkg.sv @@
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared types, constants and the 5x7 font table for the lcd column streamer.
// ----------------------------------------------------------------------------
package tlcd_pkg;

   localparam int GLYPH_COLUMNS = 5;
   localparam int GLYPH_COUNT   = 94;
   localparam int TLCD_QUEUE_DEPTH = 2;

   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] FIRST_GLYPH  = 8'h20;
   localparam logic [7:0] CMD_SET_X    = 8'h80;
   localparam logic [7:0] CMD_SET_Y    = 8'h40;
   localparam logic [7:0] BLANK_COLUMN = 8'h00;

   localparam logic [6:0] RESET_COLUMN_STEP = 7'd6;
   localparam logic [6:0] RESET_WRAP_LIMIT  = 7'd78;
   localparam logic [3:0] RESET_BANK_COUNT  = 4'd6;

   // byte positions within a run; a newline starts at the set-x position
   localparam logic [3:0] POS_LEAD_BLANK  = 4'd0;
   localparam logic [3:0] POS_TRAIL_BLANK = 4'd6;
   localparam logic [3:0] POS_SET_X       = 4'd7;
   localparam logic [3:0] POS_SET_Y       = 4'd8;

   typedef enum logic [1:0] {
      CSR_COLUMN_STEP = 2'd0,
      CSR_WRAP_LIMIT  = 2'd1,
      CSR_BANK_COUNT  = 2'd2,
      CSR_UNUSED      = 2'd3
   } tlcd_csr_type;

   typedef enum logic [1:0] {
      JOB_NEWLINE,
      JOB_GLYPH,
      JOB_GLYPH_WRAP
   } tlcd_kind_type;

   typedef struct packed {
      tlcd_kind_type kind;
      logic [6:0]    glyph;
      logic [2:0]    bank;
   } tlcd_job_type;

   // column 0 sits in the low byte of each entry
   localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700,
      40'h147f147f14, 40'h122a7f2a24, 40'h6264081323,
      40'h5022554936, 40'h0000030500, 40'h0041221c00,
      40'h001c224100, 40'h14083e0814, 40'h08083e0808,
      40'h0000305000, 40'h0808080808, 40'h0000606000,
      40'h0204081020, 40'h3e4549513e, 40'h00407f4200,
      40'h4649516142, 40'h314b454121, 40'h107f121418,
      40'h3945454527, 40'h3049494a3c, 40'h0305097101,
      40'h3649494936, 40'h1e29494906, 40'h0000363600,
      40'h0000365600, 40'h0041221408, 40'h1414141414,
      40'h0814224100, 40'h0609510102, 40'h3e41794932,
      40'h7e1111117e, 40'h364949497f, 40'h224141413e,
      40'h1c2241417f, 40'h414949497f, 40'h010909097f,
      40'h7a4949413e, 40'h7f0808087f, 40'h00417f4100,
      40'h013f414020, 40'h412214087f, 40'h404040407f,
      40'h7f020c027f, 40'h7f1008047f, 40'h3e4141413e,
      40'h060909097f, 40'h5e2151413e, 40'h462919097f,
      40'h3149494946, 40'h01017f0101, 40'h3f4040403f,
      40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
      40'h0708700807, 40'h4345495161, 40'h0041417f00,
      40'h2010080402, 40'h007f414100, 40'h0402010204,
      40'h4040404040, 40'h0004020100, 40'h7854545420,
      40'h384444487f, 40'h2044444438, 40'h7f48444438,
      40'h1854545438, 40'h0201097e08, 40'h3e5252520c,
      40'h780404087f, 40'h00407d4400, 40'h003d444020,
      40'h004428107f, 40'h00407f4100, 40'h780418047c,
      40'h780404087c, 40'h3844444438, 40'h081414147c,
      40'h7c18141408, 40'h080404087c, 40'h2054545448,
      40'h2040443f04, 40'h7c2040403c, 40'h1c2040201c,
      40'h3c4030403c, 40'h4428102844, 40'h3c5050500c,
      40'h444c546444, 40'h0041360800, 40'h00007f0000,
      40'h0008364100
   };

   function automatic logic [7:0] tlcd_font_column(input logic [6:0] glyph,
                                                   input logic [2:0] column);
      logic [39:0] entry;
      entry = FONT_ROM[glyph];
      return entry[column*8 +: 8];
   endfunction

endpackage

@@ rtl/core/tlcd_front.sv @@
// ----------------------------------------------------------------------------
// tlcd_front
// Accepts character words, keeps the cursor and config, and queues one job
// per character for the byte sequencer.
// ----------------------------------------------------------------------------
module tlcd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_code,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [6:0]            csr_data,
   input  logic                  queue_full,
   output logic                  push,
   output tlcd_pkg::tlcd_job_type push_job
);
   import tlcd_pkg::*;

   logic [6:0] column_step_ff, column_step_in;
   logic [6:0] wrap_limit_ff, wrap_limit_in;
   logic [3:0] bank_count_ff, bank_count_in;
   logic [6:0] column_ff, column_in;
   logic [2:0] bank_ff, bank_in;

   logic       is_newline;
   logic       in_font;
   logic [3:0] bank_inc;
   logic [2:0] bank_next;
   logic [7:0] column_sum;
   logic       wraps;
   logic [7:0] glyph_offset;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      is_newline   = (req_char_code == NEWLINE_CODE);
      glyph_offset = req_char_code - FIRST_GLYPH;
      in_font      = (req_char_code >= FIRST_GLYPH) &&
                     (req_char_code < FIRST_GLYPH + 8'(GLYPH_COUNT));
      bank_inc     = {1'b0, bank_ff} + 4'd1;
      // bank_count above eight acts as eight through the 3-bit wrap
      bank_next    = (bank_inc >= bank_count_ff) ? 3'd0 : bank_inc[2:0];
      column_sum   = {1'b0, column_ff} + {1'b0, column_step_ff};
      wraps        = (column_sum >= {1'b0, wrap_limit_ff});
   end

   always_comb begin
      push_job.glyph = in_font ? glyph_offset[6:0] : 7'd0;
      push_job.bank  = bank_next;
      if (is_newline) begin
         push_job.kind = JOB_NEWLINE;
      end else if (wraps) begin
         push_job.kind = JOB_GLYPH_WRAP;
      end else begin
         push_job.kind = JOB_GLYPH;
      end
   end

   always_comb begin
      column_in = column_ff;
      bank_in   = bank_ff;
      if (push) begin
         if (is_newline || wraps) begin
            column_in = 7'd0;
            bank_in   = bank_next;
         end else begin
            column_in = column_sum[6:0];
         end
      end
   end

   always_comb begin
      column_step_in = column_step_ff;
      wrap_limit_in  = wrap_limit_ff;
      bank_count_in  = bank_count_ff;
      if (csr_write) begin
         unique case (tlcd_csr_type'(csr_index))
            CSR_COLUMN_STEP: column_step_in = csr_data;
            CSR_WRAP_LIMIT:  wrap_limit_in  = csr_data;
            CSR_BANK_COUNT:  bank_count_in  = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_step_ff <= RESET_COLUMN_STEP;
         wrap_limit_ff  <= RESET_WRAP_LIMIT;
         bank_count_ff  <= RESET_BANK_COUNT;
         column_ff      <= 7'd0;
         bank_ff        <= 3'd0;
      end else begin
         column_step_ff <= column_step_in;
         wrap_limit_ff  <= wrap_limit_in;
         bank_count_ff  <= bank_count_in;
         column_ff      <= column_in;
         bank_ff        <= bank_in;
      end
   end

endmodule

@@ rtl/core/tlcd_queue.sv @@
// ----------------------------------------------------------------------------
// tlcd_queue
// Small job queue between the character front end and the byte sequencer.
// ----------------------------------------------------------------------------
module tlcd_queue #(
   parameter int DEPTH = tlcd_pkg::TLCD_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tlcd_pkg::tlcd_job_type push_job,
   input  logic                   pop,
   output tlcd_pkg::tlcd_job_type head_job,
   output logic                   not_empty,
   output logic                   full
);
   import tlcd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tlcd_job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_job  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/tlcd_back.sv @@
// ----------------------------------------------------------------------------
// tlcd_back
// Byte sequencer: walks each queued job through its run of display bytes
// into the registered result port.
// ----------------------------------------------------------------------------
module tlcd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tlcd_pkg::tlcd_job_type head_job,
   input  logic                   not_empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_data,
   output logic                   rsp_last_of_run
);
   import tlcd_pkg::*;

   logic         busy_ff, busy_in;
   logic [3:0]   pos_ff, pos_in;
   tlcd_job_type job_ff, job_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         is_data_ff, is_data_in;
   logic         last_ff, last_in;

   tlcd_job_type cur_job;
   logic [3:0]   cur_pos;
   logic         have_job;
   logic         fire;
   logic [2:0]   glyph_col;

   always_comb begin
      cur_job  = busy_ff ? job_ff : head_job;
      have_job = busy_ff | not_empty;
      if (busy_ff) begin
         cur_pos = pos_ff;
      end else if (head_job.kind == JOB_NEWLINE) begin
         cur_pos = POS_SET_X;
      end else begin
         cur_pos = POS_LEAD_BLANK;
      end
      fire      = have_job & (~rsp_valid_ff | ~rsp_stall);
      pop       = fire & ~busy_ff;
      glyph_col = 3'(cur_pos - 4'd1);
   end

   // byte for the current position
   always_comb begin
      out_byte_in = BLANK_COLUMN;
      is_data_in  = 1'b1;
      unique case (cur_pos)
         POS_LEAD_BLANK, POS_TRAIL_BLANK: begin
            out_byte_in = BLANK_COLUMN;
         end
         4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
            out_byte_in = tlcd_font_column(cur_job.glyph, glyph_col);
         end
         POS_SET_X: begin
            out_byte_in = CMD_SET_X;
            is_data_in  = 1'b0;
         end
         POS_SET_Y: begin
            out_byte_in = CMD_SET_Y | {5'd0, cur_job.bank};
            is_data_in  = 1'b0;
         end
         default: begin
            out_byte_in = BLANK_COLUMN;
         end
      endcase
      last_in = (cur_pos == POS_SET_Y) ||
                ((cur_pos == POS_TRAIL_BLANK) && (cur_job.kind == JOB_GLYPH));
   end

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
         busy_in      = ~last_in;
         pos_in       = cur_pos + 4'd1;
         job_in       = cur_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      job_ff <= job_in;
      if (fire) begin
         out_byte_ff <= out_byte_in;
         is_data_ff  <= is_data_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_is_data     = is_data_ff;
   assign rsp_last_of_run = last_ff;

endmodule

@@ rtl/core/text_to_lcd_column_stream_core.sv @@
// latency: when the sequencer is idle, the first byte of a character passes through
//   the job queue and then the result register
// throughput: one byte per cycle while a job waits and rsp_stall is low; a glyph
//   run is 7 bytes, 9 on a line wrap, a newline 2; the byte sequencer sets this pace
// reset (synchronous): cursor to column 0 bank 0, queue emptied, config registers
//   to step 6, wrap limit 78, bank count 6
// ----------------------------------------------------------------------------
// text_to_lcd_column_stream_core
// Renders character words into 5x7 glyph column bytes and position commands
// for a banked monochrome lcd.
// ----------------------------------------------------------------------------
module text_to_lcd_column_stream_core #(
   parameter int QUEUE_DEPTH = tlcd_pkg::TLCD_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_last_of_run,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);
   import tlcd_pkg::*;

   // a job queue lets new characters be taken while earlier runs are still going out
   tlcd_job_type push_job;
   tlcd_job_type head_job;
   logic         push;
   logic         pop;
   logic         not_empty;
   logic         queue_full;

   tlcd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   tlcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty),
      .full      (queue_full)
   );

   tlcd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .not_empty       (not_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ tb/text_to_lcd_column_stream_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_to_lcd_column_stream_core_tb
// Drives character words into the lcd column streamer and checks every byte
// that comes out against a cycle-free model of the cursor and font. A short
// directed table runs first, then random text under several register
// settings and flow-control patterns.
// ----------------------------------------------------------------------------
module text_to_lcd_column_stream_core_tb;
   import tlcd_pkg::*;

   localparam int NUM_PHASES       = 8;
   localparam int RANDOM_PER_PHASE = 32;
   localparam int NUM_DIRECTED     = 22;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last_of_run;
   } lcd_byte_type;

   // how a directed row gets its expected bytes
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NEWLINE,
      ROW_BLANK
   } row_check_type;

   typedef struct packed {
      logic [7:0]    code;
      row_check_type check;
      logic [2:0]    bank;
   } dir_row_type;

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code   = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_data;
   logic       rsp_last_of_run;
   logic       csr_write       = 1'b0;
   logic [1:0] csr_index       = CSR_COLUMN_STEP;
   logic [6:0] csr_data        = 7'd0;

   // tracked cursor and register copies
   logic [6:0] step_cfg   = RESET_COLUMN_STEP;
   logic [6:0] wrap_cfg   = RESET_WRAP_LIMIT;
   logic [3:0] banks_cfg  = RESET_BANK_COUNT;
   logic [6:0] cur_column = 7'd0;
   logic [2:0] cur_bank   = 3'd0;

   lcd_byte_type lcd_bytes_due [$];
   int           mismatches      = 0;
   int           send_idle_pct   = 0;
   int           recv_stall_pct  = 0;

   // 5x7 font, leftmost column in the top byte
   logic [39:0] glyph_cols [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700,
      40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001c224100,
      40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
      40'h4261514946, 40'h2141454b31, 40'h1814127f10,
      40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000,
      40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413e,
      40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
      40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
      40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
      40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
      40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
      40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
      40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204,
      40'h4040404040, 40'h0001020400, 40'h2054545478,
      40'h7f48444438, 40'h3844444420, 40'h384444487f,
      40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
      40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
      40'h7c08040478, 40'h3844444438, 40'h7c14141408,
      40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
      40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
      40'h4464544c44, 40'h0008364100, 40'h00007f0000,
      40'h0041360800
   };

   // default registers: a line holds 13 characters, six banks
   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{NEWLINE_CODE, ROW_NEWLINE, 3'd1},
      '{8'h00,        ROW_BLANK,   3'd0},
      '{8'hFF,        ROW_BLANK,   3'd0},
      '{FIRST_GLYPH,  ROW_PREDICT, 3'd0},
      '{8'h21,        ROW_PREDICT, 3'd0},
      '{8'h7D,        ROW_PREDICT, 3'd0},
      '{8'h7E,        ROW_BLANK,   3'd0},
      '{8'h1F,        ROW_BLANK,   3'd0},
      '{8'h09,        ROW_BLANK,   3'd0},
      '{8'h0B,        ROW_BLANK,   3'd0},
      '{8'h80,        ROW_BLANK,   3'd0},
      '{8'h41,        ROW_PREDICT, 3'd0},
      '{8'h7F,        ROW_BLANK,   3'd0},
      '{8'h55,        ROW_PREDICT, 3'd0},
      '{NEWLINE_CODE, ROW_NEWLINE, 3'd3},
      '{NEWLINE_CODE, ROW_NEWLINE, 3'd4},
      '{NEWLINE_CODE, ROW_NEWLINE, 3'd5},
      '{NEWLINE_CODE, ROW_NEWLINE, 3'd0},
      '{8'h5A,        ROW_PREDICT, 3'd0},
      '{8'hAA,        ROW_BLANK,   3'd0},
      '{NEWLINE_CODE, ROW_NEWLINE, 3'd1},
      '{8'h55,        ROW_PREDICT, 3'd0}
   };

   text_to_lcd_column_stream_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void queue_byte(input logic [7:0] b, input logic d, input logic l);
      lcd_byte_type entry;
      entry.out_byte    = b;
      entry.is_data     = d;
      entry.last_of_run = l;
      lcd_bytes_due.push_back(entry);
   endfunction

   // column back to zero, next bank, then set-x and set-y
   function automatic void advance_line();
      logic [3:0] nxt;
      nxt = {1'b0, cur_bank} + 4'd1;
      if (nxt >= banks_cfg) begin
         nxt = 4'd0;
      end
      cur_bank   = nxt[2:0];
      cur_column = 7'd0;
      queue_byte(CMD_SET_X | {1'b0, cur_column}, 1'b0, 1'b0);
      queue_byte(CMD_SET_Y | {5'b0, cur_bank}, 1'b0, 1'b1);
   endfunction

   function automatic void render_char(input logic [7:0] code);
      logic [39:0] cols;
      logic [7:0]  sum;
      logic        wraps;
      if (code == NEWLINE_CODE) begin
         advance_line();
      end else begin
         cols = '0;
         if (code >= FIRST_GLYPH && code < FIRST_GLYPH + GLYPH_COUNT) begin
            cols = glyph_cols[7'(code - FIRST_GLYPH)];
         end
         sum   = {1'b0, cur_column} + {1'b0, step_cfg};
         wraps = (sum >= {1'b0, wrap_cfg});
         queue_byte(BLANK_COLUMN, 1'b1, 1'b0);
         for (int k = 0; k < GLYPH_COLUMNS; k++) begin
            queue_byte(cols[39 - 8*k -: 8], 1'b1, 1'b0);
         end
         queue_byte(BLANK_COLUMN, 1'b1, !wraps);
         if (wraps) begin
            advance_line();
         end else begin
            cur_column = sum[6:0];
         end
      end
   endfunction

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         return NEWLINE_CODE;
      end else if (r < 80) begin
         return 8'($urandom_range(FIRST_GLYPH + GLYPH_COUNT - 1, FIRST_GLYPH));
      end
      return 8'($urandom_range(255));
   endfunction

   // valid stays high between back-to-back words
   task automatic send_char(input logic [7:0] code);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic write_regs(input logic [6:0] step, input logic [6:0] wrap,
                             input logic [3:0] banks);
      logic [2:0] junk;
      junk = 3'($urandom_range(7));
      csr_write <= 1'b1;
      csr_index <= CSR_COLUMN_STEP;
      csr_data  <= step;
      @(posedge clock);
      csr_index <= CSR_WRAP_LIMIT;
      csr_data  <= wrap;
      @(posedge clock);
      // upper bits are outside the bank count register
      csr_index <= CSR_BANK_COUNT;
      csr_data  <= {junk, banks};
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_data  <= 7'($urandom_range(127));
      @(posedge clock);
      csr_write <= 1'b0;
      step_cfg  = step;
      wrap_cfg  = wrap;
      banks_cfg = banks;
   endtask

   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      lcd_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lcd_bytes_due.size() == 0) begin
            $error("unexpected word: out_byte %h is_data %b last_of_run %b",
                   rsp_out_byte, rsp_is_data, rsp_last_of_run);
            mismatches++;
         end else begin
            want = lcd_bytes_due.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_is_data !== want.is_data) begin
               $error("is_data: expected %b, got %b", want.is_data, rsp_is_data);
               mismatches++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b",
                      want.last_of_run, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      int         mark;
      logic [7:0] c;
      logic [6:0] phase_step  [NUM_PHASES];
      logic [6:0] phase_wrap  [NUM_PHASES];
      logic [3:0] phase_banks [NUM_PHASES];

      phase_step  = '{7'd6, 7'd1, 7'd84, 7'd84, 7'd7, 7'd0, 7'd0, 7'd0};
      phase_wrap  = '{7'd78, 7'd84, 7'd1, 7'd84, 7'd50, 7'd0, 7'd0, 7'd0};
      phase_banks = '{4'd6, 4'd8, 4'd1, 4'd8, 4'd3, 4'd0, 4'd0, 4'd0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         send_char(directed_rows[r].code);
         mark = lcd_bytes_due.size();
         render_char(directed_rows[r].code);
         if (directed_rows[r].check != ROW_PREDICT) begin
            // keep the cursor in step but check against the typed-in bytes
            while (lcd_bytes_due.size() > mark) begin
               void'(lcd_bytes_due.pop_back());
            end
            if (directed_rows[r].check == ROW_NEWLINE) begin
               queue_byte(CMD_SET_X, 1'b0, 1'b0);
               queue_byte(CMD_SET_Y | {5'b0, directed_rows[r].bank}, 1'b0, 1'b1);
            end else begin
               for (int k = 0; k < 7; k++) begin
                  queue_byte(BLANK_COLUMN, 1'b1, k == 6);
               end
            end
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            // registers change only once the block has drained
            req_valid <= 1'b0;
            while (lcd_bytes_due.size() != 0) begin
               @(posedge clock);
            end
            if (p >= 5) begin
               phase_step[p]  = 7'($urandom_range(84, 1));
               phase_wrap[p]  = 7'($urandom_range(84, 1));
               phase_banks[p] = 4'($urandom_range(8, 1));
            end
            write_regs(phase_step[p], phase_wrap[p], phase_banks[p]);
         end
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 75;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 75;
            end
            default: begin
               send_idle_pct  = 37;
               recv_stall_pct = 37;
            end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            c = pick_char();
            send_char(c);
            render_char(c);
         end
      end

      req_valid <= 1'b0;
      while (lcd_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && lcd_bytes_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
